/* design/wls_pkg.sv */
package wls_pkg;

    localparam int STEP_BITS  = 16;
    localparam int CFG_W      = 16;
    localparam int CMP_W      = (STEP_BITS > CFG_W + 1) ? STEP_BITS : CFG_W + 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    typedef logic [3:0] t_cmd;

    localparam t_cmd CMD_NONE      = 4'd0;
    localparam t_cmd CMD_POWER_OFF = 4'd1;
    localparam t_cmd CMD_CLAMP     = 4'd2;
    localparam t_cmd CMD_RELEASE   = 4'd3;
    localparam t_cmd CMD_POINT_POS = 4'd4;
    localparam t_cmd CMD_DROP      = 4'd5;
    localparam t_cmd CMD_WELD      = 4'd6;
    localparam t_cmd CMD_RIGHT     = 4'd7;
    localparam t_cmd CMD_LEFT      = 4'd8;
    localparam t_cmd CMD_UP        = 4'd9;
    localparam t_cmd CMD_DOWN      = 4'd10;

    // config register indexes
    typedef enum logic [1:0] {
        REG_CENTER_STEPS = 2'd0,
        REG_POINT_ONE    = 2'd1,
        REG_POINT_TWO    = 2'd2,
        REG_POINT_THREE  = 2'd3
    } t_reg_idx;

    // one-hot phase encoding; phase_num() gives the dense code seen outside
    typedef enum logic [15:0] {
        PH_OFF        = 16'h0001,
        PH_ON         = 16'h0002,
        PH_WAIT_OBJ   = 16'h0004,
        PH_BEGIN      = 16'h0008,
        PH_POSITION   = 16'h0010,
        PH_NEXT_POINT = 16'h0020,
        PH_FREE       = 16'h0040,
        PH_WAIT_FREE  = 16'h0080,
        PH_FIND       = 16'h0100,
        PH_POINT_POS  = 16'h0200,
        PH_NOT_FOUND  = 16'h0400,
        PH_DOWN       = 16'h0800,
        PH_WELD       = 16'h1000,
        PH_UP         = 16'h2000,
        PH_HOME       = 16'h4000,
        PH_MOVE       = 16'h8000
    } t_phase;

    localparam logic [3:0] PHASE_OFF_NUM = 4'd0;

    function automatic logic [3:0] phase_num(input t_phase ph);
        logic [3:0] num;
        num = PHASE_OFF_NUM;
        unique case (ph)
            PH_OFF:        num = 4'd0;
            PH_ON:         num = 4'd1;
            PH_WAIT_OBJ:   num = 4'd2;
            PH_BEGIN:      num = 4'd3;
            PH_POSITION:   num = 4'd4;
            PH_NEXT_POINT: num = 4'd5;
            PH_FREE:       num = 4'd6;
            PH_WAIT_FREE:  num = 4'd7;
            PH_FIND:       num = 4'd8;
            PH_POINT_POS:  num = 4'd9;
            PH_NOT_FOUND:  num = 4'd10;
            PH_DOWN:       num = 4'd11;
            PH_WELD:       num = 4'd12;
            PH_UP:         num = 4'd13;
            PH_HOME:       num = 4'd14;
            PH_MOVE:       num = 4'd15;
            default:       num = PHASE_OFF_NUM;
        endcase
        return num;
    endfunction

endpackage

/* design/welding_line_sequencer.sv */
// Welding line sequencer: control FSM for a three-point welding station.
//
// Slave stream: one transfer per control tick, carrying the sensor snapshot
// and the power-off flag. Master stream: one actuator command per tick,
// with the phase after that tick and the halted flag.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data write center_steps (0) and the
// three signed point offsets (1..3); values act on the next tick that reads
// them. Write only while the block is idle.
//
// Output: a command is registered and appears on the master side in the
// cycle after its tick is transferred in. Throughput: one tick per cycle
// while the output is not stalled; the whole state update is one pass of the
// phase decoder between the state registers and the output register.
// Stall: s_axis_tready stays high while the output register is empty or is
// being drained, so a held result does not block the tick behind it only
// when the receiver takes it in the same cycle.
// Reset (i_rst_n low, synchronous): output empty, phase = start, step count
// and flags cleared, config registers zero. After the power-off command the
// block stays halted and answers every tick with command none, phase off.
module welding_line_sequencer
    import wls_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] object_arriving [1] object_in_place [2] head_home_left
    // [3] head_not_home [4] head_top [5] head_bottom [6] point_found
    // [7] power_off_request
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [3:0] command [7:4] phase [8] halted [15:9] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    // configuration
    logic        [CFG_W-1:0] r_center_steps;
    logic signed [CFG_W-1:0] r_offset [3];

    // control state
    t_phase               r_phase,        n_phase;
    t_phase               r_ret_move,     n_ret_move;
    t_phase               r_ret_home,     n_ret_home;
    t_cmd                 r_move_dir,     n_move_dir;
    logic [STEP_BITS-1:0] r_step_count,   n_step_count;
    logic [1:0]           r_point_idx,    n_point_idx;   // 2'b11 = none
    logic                 r_raised,       n_raised;
    logic                 r_entry_latch,  n_entry_latch;
    logic                 r_stopped,      n_stopped;

    // output register
    logic       r_out_valid;
    t_cmd       r_out_cmd,    n_out_cmd;
    logic [3:0] r_out_phase,  n_out_phase;
    logic       r_out_halted;

    logic in_xfer;

    // sensor fields
    logic arriving, in_place, home_left, not_home, top, bottom, found, power_off;
    assign arriving  = s_axis_tdata[0];
    assign in_place  = s_axis_tdata[1];
    assign home_left = s_axis_tdata[2];
    assign not_home  = s_axis_tdata[3];
    assign top       = s_axis_tdata[4];
    assign bottom    = s_axis_tdata[5];
    assign found     = s_axis_tdata[6];
    assign power_off = s_axis_tdata[7];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // target of the current point: magnitude and direction of its offset
    logic signed [CFG_W-1:0] cur_offset;
    logic                    off_neg;
    logic [CFG_W:0]          off_mag;
    logic                    step_at_max;
    logic                    raised_now;

    always_comb begin
        unique case (r_point_idx)
            2'd0:    cur_offset = r_offset[0];
            2'd1:    cur_offset = r_offset[1];
            default: cur_offset = r_offset[2];
        endcase
    end

    assign off_neg     = cur_offset[CFG_W-1];
    assign off_mag     = off_neg ? ((CFG_W+1)'(1) << CFG_W) - {1'b0, cur_offset}
                                 : {1'b0, cur_offset};
    assign step_at_max = &r_step_count;
    assign raised_now  = r_raised || (!bottom && top);

    always_comb begin
        n_phase       = r_phase;
        n_ret_move    = r_ret_move;
        n_ret_home    = r_ret_home;
        n_move_dir    = r_move_dir;
        n_step_count  = r_step_count;
        n_point_idx   = r_point_idx;
        n_raised      = r_raised;
        n_entry_latch = r_entry_latch;
        n_stopped     = r_stopped;
        n_out_cmd     = CMD_NONE;

        if (!r_stopped) begin
            unique case (r_phase)
                PH_OFF: begin
                    n_out_cmd = CMD_POWER_OFF;
                    n_stopped = 1'b1;
                end
                PH_ON: begin
                    n_ret_home = PH_WAIT_OBJ;
                    n_phase    = PH_HOME;
                    n_raised   = 1'b0;
                end
                PH_WAIT_OBJ: begin
                    n_entry_latch = arriving;
                    if (arriving) begin
                        n_phase = PH_BEGIN;
                    end
                end
                PH_BEGIN: begin
                    n_entry_latch = arriving;
                    if (in_place && !arriving) begin
                        n_out_cmd    = CMD_CLAMP;
                        n_phase      = PH_POSITION;
                        n_step_count = '0;
                        n_point_idx  = 2'b11;
                    end
                end
                PH_POSITION: begin
                    n_ret_move = PH_POSITION;
                    n_move_dir = CMD_RIGHT;
                    if (CMP_W'(r_step_count) >= CMP_W'(r_center_steps)) begin
                        n_phase = PH_NEXT_POINT;
                    end else begin
                        n_phase = PH_MOVE;
                    end
                end
                PH_NEXT_POINT: begin
                    if (r_point_idx == 2'd2) begin
                        n_phase = PH_FREE;
                    end else begin
                        n_phase      = PH_FIND;
                        n_step_count = '0;
                        n_point_idx  = r_point_idx + 2'd1;
                    end
                end
                PH_FREE: begin
                    n_out_cmd = CMD_RELEASE;
                    n_phase   = PH_WAIT_FREE;
                end
                PH_WAIT_FREE: begin
                    // tests the latched entry sensor, not the live one
                    if (!in_place && !r_entry_latch) begin
                        n_phase = PH_WAIT_OBJ;
                    end
                end
                PH_FIND: begin
                    if (r_point_idx == 2'b11) begin
                        n_phase = PH_OFF;
                    end else begin
                        n_ret_move = PH_FIND;
                        n_move_dir = (!off_neg && cur_offset != '0) ? CMD_RIGHT : CMD_LEFT;
                        if (CMP_W'(r_step_count) == CMP_W'(off_mag)) begin
                            n_phase = PH_POINT_POS;
                        end else begin
                            n_phase = PH_MOVE;
                        end
                    end
                end
                PH_POINT_POS: begin
                    n_out_cmd = CMD_POINT_POS;
                    n_phase   = found ? PH_DOWN : PH_NOT_FOUND;
                end
                PH_NOT_FOUND: begin
                    n_out_cmd = CMD_DROP;
                    n_phase   = PH_WAIT_OBJ;
                end
                PH_DOWN: begin
                    n_ret_move = PH_DOWN;
                    n_move_dir = CMD_DOWN;
                    n_phase    = (bottom && !top) ? PH_WELD : PH_MOVE;
                end
                PH_WELD: begin
                    n_out_cmd = CMD_WELD;
                    n_phase   = PH_UP;
                end
                PH_UP: begin
                    n_ret_move = PH_UP;
                    n_move_dir = CMD_UP;
                    if (!bottom && top) begin
                        n_ret_home = PH_NEXT_POINT;
                        n_phase    = PH_HOME;
                        n_raised   = 1'b0;
                    end else begin
                        n_phase = PH_MOVE;
                    end
                end
                PH_HOME: begin
                    // raise first, then step left until the home limit
                    n_ret_move = PH_HOME;
                    n_raised   = raised_now;
                    n_move_dir = raised_now ? CMD_LEFT : CMD_UP;
                    if (raised_now && home_left && !not_home) begin
                        n_phase = r_ret_home;
                    end else begin
                        n_phase = PH_MOVE;
                    end
                end
                PH_MOVE: begin
                    n_out_cmd = r_move_dir;
                    if (!step_at_max) begin
                        n_step_count = r_step_count + STEP_BITS'(1);
                    end
                    n_phase = r_ret_move;
                end
                default: begin
                    n_phase = PH_OFF;
                end
            endcase

            if (!n_stopped && power_off) begin
                n_phase = PH_OFF;
            end
        end

        n_out_phase = n_stopped ? PHASE_OFF_NUM : phase_num(n_phase);
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_steps <= '0;
            r_offset[0]    <= '0;
            r_offset[1]    <= '0;
            r_offset[2]    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CENTER_STEPS: r_center_steps <= i_cfg_data;
                REG_POINT_ONE:    r_offset[0]    <= i_cfg_data;
                REG_POINT_TWO:    r_offset[1]    <= i_cfg_data;
                REG_POINT_THREE:  r_offset[2]    <= i_cfg_data;
                default:          r_center_steps <= r_center_steps;
            endcase
        end
    end

    // control state, advanced once per input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_ON;
            r_ret_move    <= PH_OFF;
            r_ret_home    <= PH_OFF;
            r_move_dir    <= CMD_NONE;
            r_step_count  <= '0;
            r_point_idx   <= 2'b11;
            r_raised      <= 1'b0;
            r_entry_latch <= 1'b0;
            r_stopped     <= 1'b0;
        end else if (in_xfer) begin
            r_phase       <= n_phase;
            r_ret_move    <= n_ret_move;
            r_ret_home    <= n_ret_home;
            r_move_dir    <= n_move_dir;
            r_step_count  <= n_step_count;
            r_point_idx   <= n_point_idx;
            r_raised      <= n_raised;
            r_entry_latch <= n_entry_latch;
            r_stopped     <= n_stopped;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_cmd    <= n_out_cmd;
            r_out_phase  <= n_out_phase;
            r_out_halted <= n_stopped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W-9)'(0), r_out_halted, r_out_phase, r_out_cmd};

endmodule

/* design/wls_checker.sv */
module wls_checker
    import wls_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic s_xfer;
    assign s_xfer = s_axis_tvalid && s_axis_tready;

    // held result stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an input transfer always yields a result next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> m_axis_tvalid)
        else $error("no result after input transfer");

    // empty output never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // halted results report phase off and only power-off or no command
    a_halted_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |->
            m_axis_tdata[7:4] == PHASE_OFF_NUM &&
            (m_axis_tdata[3:0] == CMD_NONE || m_axis_tdata[3:0] == CMD_POWER_OFF))
        else $error("bad halted result");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:9] == '0)
        else $error("nonzero padding in result");

endmodule

bind welding_line_sequencer wls_checker u_wls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
